// ===== hdl/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmp_pkg: shared types and constants
// Types, command codes and phase codes for the trapezoid profile generator.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int VEL_BITS = 24;
  localparam int ACC_BITS = 24;
  localparam int DT_BITS  = 8;

  typedef enum logic [1:0] {
    CMD_START_ABS = 2'd0,
    CMD_START_REL = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_TICK_ALT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_CLAMP  = 2'd3
  } phase_t;

  localparam logic [0:0] REG_MAX_VEL = 1'b0;
  localparam logic [0:0] REG_MAX_ACC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_TICK_A,
    ST_TICK_B,
    ST_TICK_C,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic start_calc;
    logic div_init;
    logic div_step;
    logic start_finish;
    logic tick_a;
    logic tick_b;
    logic tick_c;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hdl/tmp_stream_if.sv =====
// ----------------------------------------------------------------------------
// tmp_stream_if: valid/ready channel
// Carries valid, ready and a packed payload between a source and a sink.
// ----------------------------------------------------------------------------
interface tmp_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmp_ctrl: sequencing state machine
// Steps the datapath through a start or a tick transaction and hands over
// the result.
// ----------------------------------------------------------------------------
module tmp_ctrl
  import tmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = status.is_start ? ST_START : ST_TICK_A;
        end
      end
      ST_START: begin
        cmd.start_calc = 1'b1;
        cmd.div_init   = 1'b1;
        state_next     = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.start_finish = 1'b1;
          state_next       = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_TICK_A: begin
        cmd.tick_a = 1'b1;
        state_next = ST_TICK_B;
      end
      ST_TICK_B: begin
        cmd.tick_b = 1'b1;
        state_next = ST_TICK_C;
      end
      ST_TICK_C: begin
        cmd.tick_c = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/tmp_datapath.sv =====
// ----------------------------------------------------------------------------
// tmp_datapath: profile arithmetic
// Holds the move state, a restoring divider for the acceleration end point
// and the velocity / distance integrators.
// ----------------------------------------------------------------------------
module tmp_datapath
  import tmp_pkg::*;
#(
  parameter int POS_BITS  = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [VEL_BITS-1:0]        cfg_data,
  input  logic [1:0]                 in_cmd,
  input  logic signed [POS_BITS-1:0] in_sensor,
  input  logic signed [POS_BITS-1:0] in_target,
  input  logic [DT_BITS-1:0]         in_dt,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 status,
  output logic signed [POS_BITS-1:0] res_pos,
  output logic [VEL_BITS-1:0]        res_vel,
  output logic [1:0]                 res_phase
);

  localparam int DB   = POS_BITS + 1;                 // whole-tick distance bits
  localparam int TB   = POS_BITS + 1 + FRAC_BITS;     // travelled bits
  localparam int V2B  = 2 * VEL_BITS;                 // vmax^2 bits
  localparam int DVB  = ACC_BITS + FRAC_BITS + 1;     // divisor bits
  localparam int CNTB = $clog2(V2B + 1);
  localparam int SB   = TB + 2;                       // signed setpoint work width
  localparam logic [TB-1:0] TRAV_MAX = {TB{1'b1}};
  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

  logic [VEL_BITS-1:0] max_vel;
  logic [ACC_BITS-1:0] max_acc;

  logic [1:0]                 r_cmd;
  logic signed [POS_BITS-1:0] r_sensor, r_target;
  logic [DT_BITS-1:0]         r_dt;

  logic signed [POS_BITS-1:0] start_pos;
  logic                       move_dir_neg;
  logic [DB-1:0]              accel_end, decel_start, move_dist;
  logic [TB-1:0]              travelled_q;
  logic [VEL_BITS-1:0]        velocity_q;

  // divider state
  logic [V2B-1:0]   dividend, quot;
  logic [V2B:0]     rem;
  logic [CNTB-1:0]  cnt;

  // tick pipeline registers
  logic [ACC_BITS+DT_BITS-1:0]  delta;
  logic [VEL_BITS+DT_BITS-1:0]  step;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_vel <= VEL_BITS'(65536);
      max_acc <= ACC_BITS'(6554);
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_VEL) max_vel <= cfg_data;
      else                          max_acc <= cfg_data[ACC_BITS-1:0];
    end
  end

  assign status.is_start = (in_cmd == CMD_START_ABS) || (in_cmd == CMD_START_REL);
  assign status.div_done = (cnt == '0);

  // start target and distance
  logic signed [POS_BITS:0] rel_sum, tgt_w, diff;
  logic signed [POS_BITS-1:0] tgt;
  logic neg_dir;
  always_comb begin
    rel_sum = $signed({r_sensor[POS_BITS-1], r_sensor})
              + $signed({r_target[POS_BITS-1], r_target});
    if (r_cmd == CMD_START_REL) begin
      if (rel_sum > $signed({PMAX[POS_BITS-1], PMAX})) tgt = PMAX;
      else if (rel_sum < $signed({PMIN[POS_BITS-1], PMIN})) tgt = PMIN;
      else tgt = rel_sum[POS_BITS-1:0];
    end else begin
      tgt = r_target;
    end
    tgt_w   = {tgt[POS_BITS-1], tgt};
    neg_dir = !(r_sensor < tgt);
    diff    = neg_dir ? ({r_sensor[POS_BITS-1], r_sensor} - tgt_w)
                      : (tgt_w - {r_sensor[POS_BITS-1], r_sensor});
  end

  // divider trial subtract
  logic [DVB-1:0] divisor;
  logic [V2B:0]   rem_sh;
  assign divisor = {max_acc, {(FRAC_BITS+1){1'b0}}};
  assign rem_sh  = {rem[V2B-1:0], dividend[V2B-1]};

  // start finish: cap against half distance
  logic [DB-1:0] mid;
  logic          flat_big;
  assign mid      = move_dist >> 1;
  assign flat_big = (max_acc == '0) || (quot >= V2B'(mid));

  // tick stage A: phase select
  logic [1:0] ph_sel;
  always_comb begin
    if (travelled_q < {accel_end, {FRAC_BITS{1'b0}}})        ph_sel = PH_ACCEL;
    else if (travelled_q < {decel_start, {FRAC_BITS{1'b0}}}) ph_sel = PH_CRUISE;
    else                                                     ph_sel = PH_DECEL;
  end

  // tick stage B: velocity update and clamp
  logic signed [ACC_BITS+DT_BITS+1:0] vel_new;
  logic [VEL_BITS-1:0] vel_cl;
  logic [1:0]          ph_cl;
  always_comb begin
    vel_new = $signed({{(ACC_BITS+DT_BITS+2-VEL_BITS){1'b0}}, velocity_q});
    if (res_phase == PH_ACCEL)
      vel_new = vel_new + $signed({2'b00, delta});
    else if (res_phase == PH_DECEL)
      vel_new = vel_new - $signed({2'b00, delta});
    ph_cl  = res_phase;
    vel_cl = vel_new[VEL_BITS-1:0];
    if (vel_new > $signed({{(ACC_BITS+DT_BITS+2-VEL_BITS){1'b0}}, max_vel})) begin
      vel_cl = max_vel;
      ph_cl  = PH_CLAMP;
    end else if (vel_new < 0) begin
      vel_cl = '0;
      ph_cl  = PH_CLAMP;
    end
  end

  // tick stage C: travel integration and setpoint
  logic [TB:0] trav_sum;
  logic [TB-1:0] trav_new;
  logic signed [SB-1:0] base, val, whole_s;
  logic [SB-1:0] mag;
  logic signed [POS_BITS-1:0] sp;
  always_comb begin
    trav_sum = {1'b0, travelled_q} + (TB+1)'(step);
    trav_new = trav_sum[TB] ? TRAV_MAX : trav_sum[TB-1:0];
    base = {{(SB-POS_BITS-FRAC_BITS){start_pos[POS_BITS-1]}}, start_pos,
            {FRAC_BITS{1'b0}}};
    val  = move_dir_neg ? base - $signed({2'b00, trav_new})
                        : base + $signed({2'b00, trav_new});
    mag  = val[SB-1] ? SB'(-val) : SB'(val);
    whole_s = $signed(mag >> FRAC_BITS);
    if (val[SB-1]) whole_s = -whole_s;
    if (whole_s > $signed({{(SB-POS_BITS){1'b0}}, PMAX})) sp = PMAX;
    else if (whole_s < $signed({{(SB-POS_BITS){1'b1}}, PMIN})) sp = PMIN;
    else sp = whole_s[POS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos    <= '0;
      move_dir_neg <= 1'b0;
      accel_end    <= '0;
      decel_start  <= '0;
      travelled_q  <= '0;
      velocity_q   <= '0;
      cnt          <= '0;
    end else begin
      if (cmd.load_in) begin
        r_cmd    <= in_cmd;
        r_sensor <= in_sensor;
        r_target <= in_target;
        r_dt     <= in_dt;
      end
      if (cmd.start_calc) begin
        start_pos    <= r_sensor;
        move_dir_neg <= neg_dir;
        move_dist    <= diff[DB-1:0];
        travelled_q  <= '0;
        velocity_q   <= '0;
        res_pos      <= r_sensor;
        res_vel      <= '0;
        res_phase    <= PH_ACCEL;
      end
      if (cmd.div_init) begin
        dividend <= max_vel * max_vel;
        rem      <= '0;
        quot     <= '0;
        cnt      <= CNTB'(V2B);
      end
      // one quotient bit per cycle
      if (cmd.div_step) begin
        dividend <= dividend << 1;
        cnt      <= cnt - 1'b1;
        if (rem_sh >= (V2B+1)'(divisor)) begin
          rem  <= rem_sh - (V2B+1)'(divisor);
          quot <= {quot[V2B-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[V2B-2:0], 1'b0};
        end
      end
      if (cmd.start_finish) begin
        if (flat_big) begin
          accel_end   <= mid;
          decel_start <= mid;
        end else begin
          accel_end   <= quot[DB-1:0];
          decel_start <= move_dist - quot[DB-1:0];
        end
      end
      if (cmd.tick_a) begin
        res_phase <= ph_sel;
        delta     <= max_acc * r_dt;
      end
      if (cmd.tick_b) begin
        velocity_q <= vel_cl;
        res_vel    <= vel_cl;
        res_phase  <= ph_cl;
        step       <= vel_cl * r_dt;
      end
      if (cmd.tick_c) begin
        travelled_q <= trav_new;
        res_pos     <= sp;
      end
    end
  end

endmodule

// ===== hdl/trapezoid_motion_profile_top.sv =====
// Flow: start = load, setup, 48-step divide, finish, output; tick = load,
// stages A/B/C, output. One item at a time, next item the cycle after hand-off.
// Start throughput is set by the one-bit-per-cycle vmax^2/(amax<<17) divider.
// Synchronous active-high reset: idle, registers at defaults, state zero.
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_top: trapezoidal setpoint generator
// Joins the controller and datapath to the stream channels and config port.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_top
  import tmp_pkg::*;
#(
  parameter int POS_BITS  = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [VEL_BITS-1:0] cfg_data,
  tmp_stream_if.sink          in_ch,
  tmp_stream_if.source        out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic signed [POS_BITS-1:0] res_pos;
  logic [VEL_BITS-1:0]        res_vel;
  logic [1:0]                 res_phase;

  tmp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status, .cmd
  );

  // input payload: {cmd, sensor_pos, target_value, elapsed_ms}
  tmp_datapath #(.POS_BITS(POS_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_cmd    (in_ch.data[2*POS_BITS+DT_BITS+1 -: 2]),
    .in_sensor (in_ch.data[2*POS_BITS+DT_BITS-1 -: POS_BITS]),
    .in_target (in_ch.data[POS_BITS+DT_BITS-1 -: POS_BITS]),
    .in_dt     (in_ch.data[DT_BITS-1:0]),
    .cmd, .status, .res_pos, .res_vel, .res_phase
  );

  // output payload: {setpoint_pos, profile_velocity, phase}
  assign out_ch.data = {res_pos, res_vel, res_phase};

endmodule

// ===== hdl/tmp_checker.sv =====
// ----------------------------------------------------------------------------
// tmp_checker: port-level checks
// Watches the top-level handshakes for sequencing slips.
// ----------------------------------------------------------------------------
module tmp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_phase
);
  // never accept while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept while result pending");
  // an accepted item does not show a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // after a transaction the block is not busy with a result
  a_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
  // stalled result holds its phase
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_phase)) else $error("phase moved");
endmodule

bind trapezoid_motion_profile_top tmp_checker u_chk (
  .clk, .rst,
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .out_phase (out_ch.data[1:0])
);

// ===== verif/tmp_stream_pkg_tb_types.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmp_tb_types: testbench transaction types
// Input and result transaction layouts for the trapezoid profile testbench.
// ----------------------------------------------------------------------------
package tmp_tb_types;
  import tmp_pkg::*;

  localparam int POS_W = 24;
  localparam int IN_W  = 2 + POS_W + POS_W + DT_BITS;
  localparam int OUT_W = POS_W + VEL_BITS + 2;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [POS_W-1:0] sensor;
    logic signed [POS_W-1:0] target;
    logic [DT_BITS-1:0]      dt;
  } motion_cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] setpoint;
    logic [VEL_BITS-1:0]     velocity;
    phase_t                  phase;
  } setpoint_t;
endpackage

// ===== verif/trapezoid_motion_profile_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_top_tb: setpoint generator testbench
// Drives start and tick transactions with bursty timing against a stalling
// sink, predicts every setpoint/velocity/phase and compares in order.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_top_tb;
  import tmp_pkg::*;
  import tmp_tb_types::*;

  localparam longint POS_MAX  = 64'sd8388607;
  localparam longint POS_MIN  = -64'sd8388608;
  localparam longint TRAV_MAX = (64'sd1 <<< 41) - 1;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [VEL_BITS-1:0] cfg_data;

  tmp_stream_if #(.W(IN_W))  in_ch ();
  tmp_stream_if #(.W(OUT_W)) out_ch ();

  trapezoid_motion_profile_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // predictor state
  longint      vmax, amax, home_pos, accel_pt, decel_pt, trav_q, vel_q;
  bit          dir_neg;
  motion_cmd_t pending[$];
  setpoint_t   expected_sp[$];
  int          errors;

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // advance the profile by one transaction, return the setpoint it produces
  function automatic setpoint_t profile_step(motion_cmd_t c);
    setpoint_t r;
    longint sensor, goal, move_len, half, flat, delta, vel, stp, val, whole;
    phase_t ph;
    if (c.cmd == CMD_START_ABS || c.cmd == CMD_START_REL) begin
      sensor = c.sensor;
      goal = (c.cmd == CMD_START_REL) ? clamp_pos(sensor + longint'(c.target))
                                      : longint'(c.target);
      home_pos = sensor;
      dir_neg = !(sensor < goal);
      move_len = dir_neg ? sensor - goal : goal - sensor;
      half = move_len / 2;
      if (amax == 0) flat = half;
      else flat = (vmax * vmax) / (amax <<< 17);
      if (half > flat) begin
        accel_pt = flat;
        decel_pt = move_len - flat;
      end else begin
        accel_pt = half;
        decel_pt = half;
      end
      trav_q = 0;
      vel_q = 0;
      r.setpoint = home_pos[POS_W-1:0];
      r.velocity = '0;
      r.phase = PH_ACCEL;
      return r;
    end
    delta = amax * longint'(c.dt);
    vel = vel_q;
    if (trav_q < (accel_pt <<< 16)) begin
      ph = PH_ACCEL;
      vel += delta;
    end else if (trav_q < (decel_pt <<< 16)) begin
      ph = PH_CRUISE;
    end else begin
      ph = PH_DECEL;
      vel -= delta;
    end
    if (vel > vmax) begin
      vel = vmax;
      ph = PH_CLAMP;
    end else if (vel < 0) begin
      vel = 0;
      ph = PH_CLAMP;
    end
    vel_q = vel;
    stp = vel_q * longint'(c.dt);
    if (stp > TRAV_MAX - trav_q) trav_q = TRAV_MAX;
    else trav_q += stp;
    val = dir_neg ? home_pos * 65536 - trav_q : home_pos * 65536 + trav_q;
    whole = (val >= 0) ? (val >>> 16) : -((-val) >>> 16);
    whole = clamp_pos(whole);
    r.setpoint = whole[POS_W-1:0];
    r.velocity = vel_q[VEL_BITS-1:0];
    r.phase = ph;
    return r;
  endfunction

  // driver: bursts of transactions with random gaps
  motion_cmd_t cur_cmd;
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_sp.push_back(profile_step(cur_cmd));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_cmd = pending.pop_front();
          in_ch.data <= cur_cmd;
          in_ch.valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  logic [15:0] stall_pat;
  setpoint_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_pat = 16'hb5a3;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_sp.size() == 0) begin
          errors++;
          $display("%0t: unexpected result sp=%0d vel=%0d ph=%s", $time,
                   got.setpoint, got.velocity, got.phase.name());
        end else begin
          want = expected_sp.pop_front();
          if (got.setpoint !== want.setpoint) begin
            errors++;
            $display("%0t: setpoint exp %0d got %0d", $time, want.setpoint, got.setpoint);
          end
          if (got.velocity !== want.velocity) begin
            errors++;
            $display("%0t: velocity exp %0d got %0d", $time, want.velocity, got.velocity);
          end
          if (got.phase !== want.phase) begin
            errors++;
            $display("%0t: phase exp %0d got %0d", $time, want.phase, got.phase);
          end
        end
      end
      // rotating stall pattern, reseeded now and then; all-ready stretches
      stall_pat = {stall_pat[14:0], stall_pat[15] ^ stall_pat[13] ^ stall_pat[12]
                   ^ stall_pat[10]};
      if ($urandom_range(0, 199) == 0) stall_pat = $urandom_range(0, 3) == 0 ? 16'hffff
                                                                           : 16'($urandom);
      if (stall_pat == 16'h0) stall_pat = 16'h1;
      out_ch.ready <= stall_pat[0] | stall_pat[3];
    end
  end

  function automatic motion_cmd_t mk(cmd_t c, longint s, longint t, int dt);
    motion_cmd_t m;
    m.cmd = c;
    m.sensor = s[POS_W-1:0];
    m.target = t[POS_W-1:0];
    m.dt = dt[7:0];
    return m;
  endfunction

  task automatic wait_idle();
    while (pending.size() > 0 || in_ch.valid || expected_sp.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[VEL_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_VEL) vmax = value & 64'hffffff;
    else amax = value & 64'hffffff;
    @(posedge clk);
  endtask

  // one well-formed move: a start and a run of ticks
  task automatic queue_move(int span, int ticks, int dt_hi);
    longint s;
    int k;
    s = $urandom_range(0, 4) == 0 ? longint'($signed(24'($urandom)))
                                  : longint'($urandom_range(0, 2000)) - 1000;
    if ($urandom_range(0, 1) == 0)
      pending.push_back(mk(CMD_START_REL, s, longint'($urandom_range(0, 2 * span)) - span, 0));
    else
      pending.push_back(mk(CMD_START_ABS, s,
                           clamp_pos(s + longint'($urandom_range(0, 2 * span)) - span), 0));
    for (k = 0; k < ticks; k++)
      pending.push_back(mk($urandom_range(0, 9) == 0 ? CMD_TICK_ALT : CMD_TICK,
                           $urandom, $urandom, $urandom_range(0, dt_hi)));
  endtask

  task automatic queue_noise(int n);
    int k;
    for (k = 0; k < n; k++)
      pending.push_back(mk(cmd_t'($urandom_range(0, 3)), longint'($signed(24'($urandom))),
                           longint'($signed(24'($urandom))), $urandom_range(0, 255)));
  endtask

  initial begin
    int p;
    errors = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    vmax = 65536; amax = 6554;
    home_pos = 0; dir_neg = 0; accel_pt = 0; decel_pt = 0; trav_q = 0; vel_q = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tick from reset, extremes, overflow, equal target, cmd 3, dt 0
    pending.push_back(mk(CMD_TICK, 0, 0, 10));
    pending.push_back(mk(CMD_START_ABS, POS_MIN, POS_MAX, 0));
    repeat (4) pending.push_back(mk(CMD_TICK, 0, 0, 255));
    pending.push_back(mk(CMD_START_REL, POS_MAX, POS_MAX, 0));
    pending.push_back(mk(CMD_TICK, 0, 0, 0));
    pending.push_back(mk(CMD_START_REL, POS_MIN, POS_MIN, 0));
    pending.push_back(mk(CMD_TICK_ALT, -1, -1, 255));
    pending.push_back(mk(CMD_START_ABS, 1234, 1234, 0));
    pending.push_back(mk(CMD_TICK, 0, 0, 50));
    pending.push_back(mk(CMD_START_ABS, 0, 3, 0));
    repeat (6) pending.push_back(mk(CMD_TICK, 0, 0, 20));
    pending.push_back(mk(CMD_START_REL, -5, -40, 0));
    repeat (4) pending.push_back(mk(CMD_TICK, -1, -1, 128));
    wait_idle();

    // extremes: fastest setting, long moves hitting saturation
    write_reg(REG_MAX_VEL, 24'hffffff);
    write_reg(REG_MAX_ACC, 24'hffffff);
    pending.push_back(mk(CMD_START_ABS, POS_MAX - 100, POS_MIN, 0));
    repeat (8) pending.push_back(mk(CMD_TICK, 0, 0, 255));
    queue_move(8000000, 20, 255);
    wait_idle();

    // slowest setting
    write_reg(REG_MAX_VEL, 1);
    write_reg(REG_MAX_ACC, 1);
    queue_move(50, 15, 255);
    wait_idle();

    // zero acceleration
    write_reg(REG_MAX_ACC, 0);
    queue_move(200, 8, 255);
    wait_idle();

    // random settings, mostly well-formed moves
    for (p = 0; p < 6; p++) begin
      write_reg(REG_MAX_VEL, $urandom_range(1000, 400000));
      write_reg(REG_MAX_ACC, $urandom_range(100, 60000));
      repeat (3) queue_move($urandom_range(20, 3000), $urandom_range(8, 30), 40);
      queue_noise(6);
      if (p == 4) begin
        // velocity limit dropped mid-move
        wait_idle();
        write_reg(REG_MAX_VEL, 2000);
        repeat (6) pending.push_back(mk(CMD_TICK, 0, 0, 30));
      end
      wait_idle();
    end

    repeat (60) @(posedge clk);
    if (errors == 0 && expected_sp.size() == 0)
      $display("trapezoid_motion_profile_top_tb: clean");
    else begin
      if (expected_sp.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_sp.size());
      $display("trapezoid_motion_profile_top_tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("trapezoid_motion_profile_top_tb: errors");
    $finish;
  end
endmodule

// ===== trapezoid_motion_profile_top.f =====
hdl/tmp_pkg.sv
hdl/tmp_stream_if.sv
hdl/tmp_ctrl.sv
hdl/tmp_datapath.sv
hdl/trapezoid_motion_profile_top.sv
hdl/tmp_checker.sv
verif/tmp_stream_pkg_tb_types.sv
verif/trapezoid_motion_profile_top_tb.sv
